// ===== src/ilid_pkg.sv =====
// Shared types and constants for the indexed insert/delete list.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ilid_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 10;
    localparam int KIND_W = 3;
    localparam int LEN_W  = 9;

    // Fan-in of each node of the registered read tree
    localparam int RADIX = 16;

    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FRONT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

    localparam logic [DATA_W-1:0] NOT_FOUND_VALUE = '1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } ilid_state_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/ilid_cell.sv =====
// One storage cell of the list: holds one entry and takes its neighbor's
// entry on an insert or delete. Depends on ilid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilid_cell
    import ilid_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDXW  = 8
)
(
    input  wire logic              clk,
    input  wire cell_ctl_t         ctl,
    input  wire logic [IDXW-1:0]   pos,
    input  wire logic [DATA_W-1:0] lower_value,
    input  wire logic [DATA_W-1:0] upper_value,
    output logic      [DATA_W-1:0] entry_value
);

    localparam logic [IDXW-1:0] MY_INDEX = IDXW'(INDEX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            // open the gap: cells above the slot take the lower neighbor
            if (MY_INDEX == pos)
                entry_next = ctl.value;
            else if (MY_INDEX > pos)
                entry_next = lower_value;
        end
        else if (ctl.del)
        begin
            // close the gap: the slot and above take the upper neighbor
            if (MY_INDEX >= pos)
                entry_next = upper_value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_value = entry_reg;

endmodule

`default_nettype wire

// ===== src/ilid_read_tree.sv =====
// Registered OR tree that picks one cell's entry by position.
// Depends on ilid_pkg; fed by the row of ilid_cell instances.
`timescale 1ns / 1ps
`default_nettype none

module ilid_read_tree
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int IDXW     = 8
)
(
    input  wire logic              clk,
    input  wire logic [DATA_W-1:0] cell_values [CAPACITY],
    input  wire logic [IDXW-1:0]   rd_pos,
    output logic      [DATA_W-1:0] root_value
);

    function automatic int tree_levels(input int cap);
        int n;
        int l;
        n = 1;
        l = 0;
        while (n < cap)
        begin
            n = n * RADIX;
            l = l + 1;
        end
        return l;
    endfunction

    localparam int LVLS   = tree_levels(CAPACITY);
    localparam int LEAVES = RADIX ** LVLS;

    function automatic int level_width(input int l);
        return RADIX ** (LVLS - l);
    endfunction

    function automatic int level_off(input int l);
        int s;
        s = 0;
        for (int j = 1; j < l; j++)
            s = s + level_width(j);
        return s;
    endfunction

    localparam int TOTAL = level_off(LVLS + 1);

    logic [DATA_W-1:0] leaf     [LEAVES];
    logic [DATA_W-1:0] tree_reg [TOTAL];

    // mask every cell except the addressed one
    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < CAPACITY)
        begin : g_live
            assign leaf[i] = (rd_pos == IDXW'(i)) ? cell_values[i] : '0;
        end
        else
        begin : g_pad
            assign leaf[i] = '0;
        end
    end

    for (genvar l = 1; l <= LVLS; l++)
    begin : g_level
        for (genvar i = 0; i < level_width(l); i++)
        begin : g_node
            logic [DATA_W-1:0] or_acc;
            if (l == 1)
            begin : g_from_leaf
                always_comb
                begin
                    or_acc = '0;
                    for (int k = 0; k < RADIX; k++)
                        or_acc = or_acc | leaf[RADIX * i + k];
                end
            end
            else
            begin : g_from_node
                always_comb
                begin
                    or_acc = '0;
                    for (int k = 0; k < RADIX; k++)
                        or_acc = or_acc | tree_reg[level_off(l - 1) + RADIX * i + k];
                end
            end
            always_ff @(posedge clk)
            begin
                tree_reg[level_off(l) + i] <= or_acc;
            end
        end
    end

    assign root_value = tree_reg[TOTAL - 1];

endmodule

`default_nettype wire

// ===== src/indexed_list_insert_delete_core.sv =====
// Indexed insert/delete list: top level with controller, cell row and read tree.
// Depends on ilid_pkg, ilid_cell and ilid_read_tree.
//
// Usage:
//   Requests arrive on the in_valid/in_ready channel (kind, position, value);
//   each request yields exactly one result transaction on out_valid/out_ready
//   (read_value, found, accepted, length). Results leave in request order.
//   The list is a row of CAPACITY cells. Inserts and deletes shift the cells
//   at and above the position in parallel, so write-type requests (insert
//   front, append, insert at position, delete, unused kinds) are taken one
//   per cycle while the receiver keeps up; their result is valid in the
//   cycle after acceptance. A read selects its entry through a registered OR
//   tree of radix 16 with L = ceil(log16(CAPACITY)) levels (L = 2 at CAPACITY
//   256). A read waits in the read state while the L tree levels fill, then
//   loads its result once the output register is free. A single output
//   register holds the result; a new request is taken while no read is in
//   progress and that register is empty or is being drained in the same
//   cycle. When the receiver stalls, hold the result and stop taking requests.
//   Reset clears the element count, the controller state and out_valid;
//   cell contents are not cleared and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_delete_core
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [KIND_W-1:0]        kind,
    input  wire logic signed [POS_W-1:0]  position,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      read_value,
    output logic                          found,
    output logic                          accepted,
    output logic [LEN_W-1:0]              length
);

    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW = $clog2(CAPACITY + 1);
    // compare width: wide enough for the count and for a 9-bit position
    localparam int CMPW = (CNTW > LEN_W) ? CNTW : LEN_W;

    function automatic int tree_levels(input int cap);
        int n;
        int l;
        n = 1;
        l = 0;
        while (n < cap)
        begin
            n = n * RADIX;
            l = l + 1;
        end
        return l;
    endfunction

    localparam int LVLS  = tree_levels(CAPACITY);
    localparam int WAITW = $clog2(LVLS + 1);
    localparam logic [WAITW-1:0] WAIT_LOAD = WAITW'(LVLS);
    localparam logic [CNTW-1:0]  FULL_COUNT = CNTW'(CAPACITY);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    ilid_state_t       state_reg, state_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [WAITW-1:0]  wait_reg, wait_next;
    logic [IDXW-1:0]   rd_pos_reg, rd_pos_next;
    logic              rd_hit_reg, rd_hit_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_found_reg, out_found_next;
    logic              out_acc_reg, out_acc_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    logic              in_fire;
    logic              slot_free;
    logic              pos_neg;
    logic [CMPW-1:0]   pos_ext;
    logic [CMPW-1:0]   cnt_ext;
    logic              full;
    logic              rd_hit;
    logic              is_ins;
    logic              ins_ok;
    logic              do_ins;
    logic              do_del;
    logic [IDXW-1:0]   ins_pos;
    logic [IDXW-1:0]   cell_pos;
    cell_ctl_t         ctl;
    logic [DATA_W-1:0] root_value;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign in_fire   = in_valid && in_ready;

    assign pos_neg = position[POS_W-1];
    assign pos_ext = CMPW'(position[LEN_W-1:0]);
    assign cnt_ext = CMPW'(count_reg);
    assign full    = (count_reg == FULL_COUNT);
    assign rd_hit  = !pos_neg && (pos_ext < cnt_ext);

    always_comb
    begin
        is_ins  = 1'b0;
        ins_ok  = 1'b0;
        ins_pos = '0;
        case (kind)
            KIND_FRONT:
            begin
                is_ins  = 1'b1;
                ins_ok  = 1'b1;
                ins_pos = '0;
            end
            KIND_APPEND:
            begin
                is_ins  = 1'b1;
                ins_ok  = 1'b1;
                ins_pos = cnt_ext[IDXW-1:0];
            end
            KIND_INSERT:
            begin
                is_ins  = 1'b1;
                ins_ok  = !pos_neg && (pos_ext <= cnt_ext);
                ins_pos = pos_ext[IDXW-1:0];
            end
            default:
            begin
                is_ins  = 1'b0;
                ins_ok  = 1'b0;
                ins_pos = '0;
            end
        endcase
    end

    assign do_ins = in_fire && is_ins && ins_ok && !full;
    assign do_del = in_fire && (kind == KIND_DELETE) && rd_hit;

    assign cell_pos  = do_del ? pos_ext[IDXW-1:0] : ins_pos;
    assign ctl.ins   = do_ins;
    assign ctl.del   = do_del;
    assign ctl.value = value;

    // ---------------------------------------------------------------
    // Controller: next state and result loading
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        wait_next      = wait_reg;
        rd_pos_next    = rd_pos_reg;
        rd_hit_next    = rd_hit_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_found_next = out_found_reg;
        out_acc_next   = out_acc_reg;
        out_len_next   = out_len_reg;

        // drop the result once the receiver takes it
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (do_ins)
            count_next = count_reg + CNTW'(1);
        else if (do_del)
            count_next = count_reg - CNTW'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == KIND_READ)
                    begin
                        // hold the position while the tree settles
                        rd_pos_next = pos_ext[IDXW-1:0];
                        rd_hit_next = rd_hit;
                        wait_next   = WAIT_LOAD;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_found_next = 1'b0;
                        out_acc_next   = do_ins || do_del;
                        out_len_next   = LEN_W'(count_next);
                    end
                end
            end
            ST_READ:
            begin
                if (wait_reg != '0)
                    wait_next = wait_reg - WAITW'(1);
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rd_hit_reg ? root_value : NOT_FOUND_VALUE;
                    out_found_next = rd_hit_reg;
                    out_acc_next   = 1'b0;
                    out_len_next   = cnt_ext[LEN_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        rd_pos_reg    <= rd_pos_next;
        rd_hit_reg    <= rd_hit_next;
        out_value_reg <= out_value_next;
        out_found_reg <= out_found_next;
        out_acc_reg   <= out_acc_next;
        out_len_reg   <= out_len_next;
    end

    // ---------------------------------------------------------------
    // Row of cells: each one hands its entry to both neighbors
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] cell_values [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] lower_value;
        logic [DATA_W-1:0] upper_value;

        if (i == 0)
        begin : g_first
            assign lower_value = '0;
        end
        else
        begin : g_mid_lo
            assign lower_value = cell_values[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_value = cell_values[i];
        end
        else
        begin : g_mid_hi
            assign upper_value = cell_values[i + 1];
        end

        ilid_cell #(
            .INDEX (i),
            .IDXW  (IDXW)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .pos         (cell_pos),
            .lower_value (lower_value),
            .upper_value (upper_value),
            .entry_value (cell_values[i])
        );
    end

    // ---------------------------------------------------------------
    // Read path
    // ---------------------------------------------------------------
    ilid_read_tree #(
        .CAPACITY (CAPACITY),
        .IDXW     (IDXW)
    ) u_read_tree (
        .clk         (clk),
        .cell_values (cell_values),
        .rd_pos      (rd_pos_reg),
        .root_value  (root_value)
    );

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign found      = out_found_reg;
    assign accepted   = out_acc_reg;
    assign length     = out_len_reg;

endmodule

`default_nettype wire
